FILE: rtl/rdbd_pkg.sv
// Shared constants, command and status codes, and FSM state type for the radix bucket distributor.
package rdbd_pkg;

  localparam int MAX_RADIX    = 16;
  localparam int BUCKET_DEPTH = 256;
  localparam int VALUE_BITS   = 32;

  localparam int RADIX_BITS  = $clog2(MAX_RADIX);
  localparam int REFF_BITS   = $clog2(MAX_RADIX + 1);
  localparam int IDX_BITS    = $clog2(BUCKET_DEPTH);
  localparam int FILL_BITS   = $clog2(BUCKET_DEPTH + 1);
  localparam int STORE_DEPTH = MAX_RADIX * BUCKET_DEPTH;
  localparam int DCNT_BITS   = $clog2(VALUE_BITS);
  localparam int PROD_BITS   = VALUE_BITS + REFF_BITS;

  // Fixed field widths of the ports
  localparam int CMD_W   = 2;
  localparam int SEL_W   = 4;
  localparam int ENTRY_W = 8;
  localparam int BKT_W   = 4;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;
  localparam int RAD_W   = 5;
  localparam int POS_W   = 6;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [RAD_W-1:0] RADIX_RESET = RAD_W'(10);
  localparam logic [POS_W-1:0] POS_RESET   = POS_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_POS = CFG_IDX_W'(1);

  localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(2);

  localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_FULL  = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_RANGE = STAT_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL_RQ,
    ST_FILL,
    ST_STORE,
    ST_RESULT
  } rdbd_state_t;

endpackage

FILE: rtl/rdbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module rdbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/radix_digit_bucket_distributor.sv
// Top level of the radix sort bucket distribution pass.
// One pass of a radix sort. An insert transaction extracts the digit of the value at the
// configured position and base, digit = (value / radix^(digit_position-1)) mod radix, and
// appends the value to that digit's bucket; the result carries the digit and the new count
// (status FULL and the unchanged count when the bucket already holds BUCKET_DEPTH entries).
// A read transaction returns one entry of a bucket with its count (status RANGE past the
// fill). A clear transaction empties every bucket. Items are handled one at a time.
// An insert runs through ST_DIV, where the bit-serial restoring divider produces one
// quotient bit per cycle while it folds the quotient modulo the radix (skipped when the
// power exceeds the value range), then ST_FILL_RQ, ST_FILL and ST_RESULT; a read runs
// through ST_FILL_RQ, ST_FILL, ST_STORE when the entry is fetched from the store, and
// ST_RESULT; clear and unused commands go straight to ST_RESULT. The divisor
// radix^(digit_position-1) is rebuilt after every configuration write by a multiply-by-radix
// loop, one factor per cycle; input stalls until it is done. Buckets live in a MAX_RADIX x
// BUCKET_DEPTH synchronous RAM; fill counts in a small RAM with one valid flag per bucket,
// which reset and clear drop at once, so no clearing pass is needed. A finished result sits
// in the output register while the next transaction is accepted.
module radix_digit_bucket_distributor (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [rdbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdbd_pkg::CFG_W-1:0]    cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rdbd_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rdbd_pkg::VALUE_BITS-1:0] in_value,
  input  logic [rdbd_pkg::SEL_W-1:0]    in_bucket_select,
  input  logic [rdbd_pkg::ENTRY_W-1:0]  in_entry_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rdbd_pkg::VALUE_BITS-1:0] out_read_value,
  output logic [rdbd_pkg::BKT_W-1:0]    out_bucket_index,
  output logic [rdbd_pkg::COUNT_W-1:0]  out_bucket_count,
  output logic [rdbd_pkg::STAT_W-1:0]   out_status
);

  localparam int VB = rdbd_pkg::VALUE_BITS;
  localparam int RB = rdbd_pkg::RADIX_BITS;
  localparam int EB = rdbd_pkg::REFF_BITS;
  localparam int FB = rdbd_pkg::FILL_BITS;
  localparam int IB = rdbd_pkg::IDX_BITS;
  localparam int PB = rdbd_pkg::PROD_BITS;
  localparam int AB = $clog2(rdbd_pkg::STORE_DEPTH);

  // configuration registers
  logic [rdbd_pkg::RAD_W-1:0] radix_r;
  logic [rdbd_pkg::POS_W-1:0] pos_r;

  // divisor power unit
  logic [VB-1:0]              pow_r, pow_nxt;
  logic                       pow_ovf_r, pow_ovf_nxt;
  logic [rdbd_pkg::POS_W-1:0] pow_cnt_r, pow_cnt_nxt;
  logic                       pow_load_r, pow_load_nxt;
  logic                       pow_busy_r, pow_busy_nxt;

  // transaction control
  rdbd_pkg::rdbd_state_t      state_r, state_nxt;
  logic [rdbd_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [VB-1:0]              val_r, val_nxt;
  logic [RB-1:0]              bkt_r, bkt_nxt;
  logic                       oob_r, oob_nxt;
  logic [rdbd_pkg::ENTRY_W-1:0] idx_r, idx_nxt;
  logic [VB-1:0]              rem_r, rem_nxt;
  logic [RB-1:0]              mod_r, mod_nxt;
  logic [rdbd_pkg::DCNT_BITS-1:0] dcnt_r, dcnt_nxt;
  logic [rdbd_pkg::MAX_RADIX-1:0] fill_vld_r, fill_vld_nxt;

  // pending result
  logic [VB-1:0]                res_value_r, res_value_nxt;
  logic [RB-1:0]                res_bkt_r, res_bkt_nxt;
  logic [FB-1:0]                res_count_r, res_count_nxt;
  logic [rdbd_pkg::STAT_W-1:0]  res_stat_r, res_stat_nxt;

  // output register
  logic                         out_valid_r;
  logic [VB-1:0]                out_value_r;
  logic [rdbd_pkg::BKT_W-1:0]   out_bkt_r;
  logic [rdbd_pkg::COUNT_W-1:0] out_count_r;
  logic [rdbd_pkg::STAT_W-1:0]  out_stat_r;
  logic                         out_load;

  // memories
  logic          store_we;
  logic [AB-1:0] store_waddr, store_raddr;
  logic [VB-1:0] store_rdata;
  logic          fill_we;
  logic [FB-1:0] fill_wdata, fill_rdata;

  // datapath helpers
  logic [EB-1:0] r_eff;
  logic [rdbd_pkg::POS_W-1:0] pos_eff;
  logic [PB-1:0] prod;
  logic [VB:0]   rem_sh;
  logic          qbit;
  logic [RB:0]   mod_sh;
  logic [RB-1:0] mod_step;
  logic [FB-1:0] fill_cur;
  logic          accept;

  // Effective radix: clamp into [2, MAX_RADIX]; position zero acts as one
  always_comb begin
    if (radix_r < rdbd_pkg::RAD_W'(2)) begin
      r_eff = EB'(2);
    end else if (32'(radix_r) > rdbd_pkg::MAX_RADIX) begin
      r_eff = EB'(rdbd_pkg::MAX_RADIX);
    end else begin
      r_eff = EB'(radix_r);
    end
    pos_eff = (pos_r == '0) ? rdbd_pkg::POS_W'(1) : pos_r;
  end

  assign prod = PB'(pow_r) * PB'(r_eff);

  // One restoring-division step; the quotient bit is folded into a running mod-radix
  assign rem_sh   = {rem_r, val_r[dcnt_r]};
  assign qbit     = (rem_sh >= {1'b0, pow_r});
  assign mod_sh   = {mod_r, qbit};
  assign mod_step = ((RB+1)'(mod_sh) >= (RB+1)'(r_eff)) ? RB'(mod_sh - (RB+1)'(r_eff))
                                                        : RB'(mod_sh);

  assign fill_cur = fill_vld_r[bkt_r] ? fill_rdata : '0;

  assign in_stall = (state_r != rdbd_pkg::ST_IDLE) || pow_load_r || pow_busy_r;
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == rdbd_pkg::ST_RESULT) && (!out_valid_r || !out_stall);

  assign store_waddr = {bkt_r, fill_cur[IB-1:0]};
  assign store_raddr = {bkt_r, IB'(idx_r)};
  assign fill_wdata  = fill_cur + FB'(1);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    bkt_nxt       = bkt_r;
    oob_nxt       = oob_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    mod_nxt       = mod_r;
    dcnt_nxt      = dcnt_r;
    fill_vld_nxt  = fill_vld_r;
    res_value_nxt = res_value_r;
    res_bkt_nxt   = res_bkt_r;
    res_count_nxt = res_count_r;
    res_stat_nxt  = res_stat_r;
    store_we      = 1'b0;
    fill_we       = 1'b0;

    pow_nxt      = pow_r;
    pow_ovf_nxt  = pow_ovf_r;
    pow_cnt_nxt  = pow_cnt_r;
    pow_load_nxt = 1'b0;
    pow_busy_nxt = pow_busy_r;

    // divisor rebuild after a configuration write
    if (cfg_we) begin
      pow_load_nxt = 1'b1;
      pow_busy_nxt = 1'b0;
    end else if (pow_load_r) begin
      pow_nxt      = VB'(1);
      pow_ovf_nxt  = 1'b0;
      pow_cnt_nxt  = pos_eff - rdbd_pkg::POS_W'(1);
      pow_busy_nxt = 1'b1;
    end else if (pow_busy_r) begin
      if (pow_cnt_r == '0) begin
        pow_busy_nxt = 1'b0;
      end else if (prod[PB-1:VB] != '0) begin
        // power exceeds the value range: digit is forced to zero
        pow_ovf_nxt  = 1'b1;
        pow_busy_nxt = 1'b0;
      end else begin
        pow_nxt     = prod[VB-1:0];
        pow_cnt_nxt = pow_cnt_r - rdbd_pkg::POS_W'(1);
      end
    end

    case (state_r)
      rdbd_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          case (in_cmd)
            rdbd_pkg::CMD_INSERT: begin
              val_nxt = in_value;
              if (pow_ovf_r) begin
                bkt_nxt   = '0;
                state_nxt = rdbd_pkg::ST_FILL_RQ;
              end else begin
                rem_nxt   = '0;
                mod_nxt   = '0;
                dcnt_nxt  = rdbd_pkg::DCNT_BITS'(VB - 1);
                state_nxt = rdbd_pkg::ST_DIV;
              end
            end
            rdbd_pkg::CMD_READ: begin
              bkt_nxt   = RB'(in_bucket_select);
              oob_nxt   = (32'(in_bucket_select) >= rdbd_pkg::MAX_RADIX);
              idx_nxt   = in_entry_index;
              state_nxt = rdbd_pkg::ST_FILL_RQ;
            end
            rdbd_pkg::CMD_CLEAR: begin
              fill_vld_nxt  = '0;
              res_value_nxt = '0;
              res_bkt_nxt   = '0;
              res_count_nxt = '0;
              res_stat_nxt  = rdbd_pkg::STAT_OK;
              state_nxt     = rdbd_pkg::ST_RESULT;
            end
            default: begin
              res_value_nxt = '0;
              res_bkt_nxt   = '0;
              res_count_nxt = '0;
              res_stat_nxt  = rdbd_pkg::STAT_OK;
              state_nxt     = rdbd_pkg::ST_RESULT;
            end
          endcase
        end
      end

      rdbd_pkg::ST_DIV: begin
        rem_nxt = qbit ? VB'(rem_sh - {1'b0, pow_r}) : rem_sh[VB-1:0];
        mod_nxt = mod_step;
        if (dcnt_r == '0) begin
          bkt_nxt   = mod_step;
          state_nxt = rdbd_pkg::ST_FILL_RQ;
        end else begin
          dcnt_nxt = dcnt_r - rdbd_pkg::DCNT_BITS'(1);
        end
      end

      // fill RAM read in flight
      rdbd_pkg::ST_FILL_RQ: begin
        state_nxt = rdbd_pkg::ST_FILL;
      end

      rdbd_pkg::ST_FILL: begin
        res_value_nxt = '0;
        res_bkt_nxt   = bkt_r;
        if (cmd_r == rdbd_pkg::CMD_INSERT) begin
          if (32'(fill_cur) >= rdbd_pkg::BUCKET_DEPTH) begin
            res_count_nxt = fill_cur;
            res_stat_nxt  = rdbd_pkg::STAT_FULL;
          end else begin
            store_we              = 1'b1;
            fill_we               = 1'b1;
            fill_vld_nxt[bkt_r]   = 1'b1;
            res_count_nxt         = fill_wdata;
            res_stat_nxt          = rdbd_pkg::STAT_OK;
          end
          state_nxt = rdbd_pkg::ST_RESULT;
        end else if (oob_r) begin
          res_count_nxt = '0;
          res_stat_nxt  = rdbd_pkg::STAT_RANGE;
          state_nxt     = rdbd_pkg::ST_RESULT;
        end else if (FB'(idx_r) >= fill_cur || 32'(idx_r) >= rdbd_pkg::BUCKET_DEPTH) begin
          res_count_nxt = fill_cur;
          res_stat_nxt  = rdbd_pkg::STAT_RANGE;
          state_nxt     = rdbd_pkg::ST_RESULT;
        end else begin
          // entry read issued this cycle
          res_count_nxt = fill_cur;
          res_stat_nxt  = rdbd_pkg::STAT_OK;
          state_nxt     = rdbd_pkg::ST_STORE;
        end
      end

      rdbd_pkg::ST_STORE: begin
        res_value_nxt = store_rdata;
        state_nxt     = rdbd_pkg::ST_RESULT;
      end

      rdbd_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = rdbd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rdbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= rdbd_pkg::RADIX_RESET;
      pos_r      <= rdbd_pkg::POS_RESET;
      pow_r      <= VB'(1);
      pow_ovf_r  <= 1'b0;
      pow_cnt_r  <= '0;
      pow_load_r <= 1'b0;
      pow_busy_r <= 1'b0;
      state_r    <= rdbd_pkg::ST_IDLE;
      fill_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdbd_pkg::REG_RADIX:     radix_r <= cfg_wdata[rdbd_pkg::RAD_W-1:0];
          rdbd_pkg::REG_DIGIT_POS: pos_r   <= cfg_wdata[rdbd_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      pow_r      <= pow_nxt;
      pow_ovf_r  <= pow_ovf_nxt;
      pow_cnt_r  <= pow_cnt_nxt;
      pow_load_r <= pow_load_nxt;
      pow_busy_r <= pow_busy_nxt;
      state_r    <= state_nxt;
      fill_vld_r <= fill_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    bkt_r       <= bkt_nxt;
    oob_r       <= oob_nxt;
    idx_r       <= idx_nxt;
    rem_r       <= rem_nxt;
    mod_r       <= mod_nxt;
    dcnt_r      <= dcnt_nxt;
    res_value_r <= res_value_nxt;
    res_bkt_r   <= res_bkt_nxt;
    res_count_r <= res_count_nxt;
    res_stat_r  <= res_stat_nxt;
    if (out_load) begin
      out_value_r <= res_value_r;
      out_bkt_r   <= rdbd_pkg::BKT_W'(res_bkt_r);
      out_count_r <= rdbd_pkg::COUNT_W'(res_count_r);
      out_stat_r  <= res_stat_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_bucket_index = out_bkt_r;
  assign out_bucket_count = out_count_r;
  assign out_status       = out_stat_r;

  // bucket entries
  rdbd_ram #(
    .WIDTH (VB),
    .DEPTH (rdbd_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (val_r),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // per-bucket fill counts, qualified by fill_vld_r
  rdbd_ram #(
    .WIDTH (FB),
    .DEPTH (rdbd_pkg::MAX_RADIX)
  ) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (bkt_r),
    .wdata (fill_wdata),
    .raddr (bkt_r),
    .rdata (fill_rdata)
  );

endmodule

FILE: tb/tb_radix_digit_bucket_distributor.sv
// Self-checking testbench for the radix sort bucket distribution pass.
`timescale 1ns / 100ps

module tb_radix_digit_bucket_distributor;
  import rdbd_pkg::*;

  // Command code the block does not define; it must come back as an all-zero result
  localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);
  localparam longint unsigned VALUE_MASK = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  // Slowest transaction is an insert; leave room after the drain
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic [BKT_W-1:0]      bucket_index;
    logic [COUNT_W-1:0]    bucket_count;
    logic [STAT_W-1:0]     status;
  } bucket_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic [SEL_W-1:0]      in_bucket_select = '0;
  logic [ENTRY_W-1:0]    in_entry_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_read_value;
  logic [BKT_W-1:0]      out_bucket_index;
  logic [COUNT_W-1:0]    out_bucket_count;
  logic [STAT_W-1:0]     out_status;

  radix_digit_bucket_distributor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_bucket_select (in_bucket_select),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_bucket_index (out_bucket_index),
    .out_bucket_count (out_bucket_count),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: bucket contents, fill counts and both registers.
  // Store entries past a bucket's fill are never looked at, so the store needs
  // no reset here either.
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] shadow_store [MAX_RADIX][BUCKET_DEPTH];
  int unsigned           shadow_fill [MAX_RADIX];
  logic [RAD_W-1:0]      shadow_radix = RADIX_RESET;
  logic [POS_W-1:0]      shadow_digit_pos = POS_RESET;

  bucket_result_t pending_results[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  initial begin
    foreach (shadow_fill[b]) shadow_fill[b] = 0;
  end

  // Digit of v at the configured position. Radix is clamped to 2..MAX_RADIX,
  // position 0 means 1, and a power that no longer fits the value range
  // forces digit 0.
  function automatic logic [BKT_W-1:0] digit_at_position(logic [VALUE_BITS-1:0] v);
    longint unsigned base;
    longint unsigned power;
    int unsigned     place;
    base  = (shadow_radix < 2) ? 2 : (shadow_radix > MAX_RADIX) ? MAX_RADIX : shadow_radix;
    place = (shadow_digit_pos == 0) ? 1 : shadow_digit_pos;
    power = 1;
    for (int k = 1; k < place; k++) begin
      if (power > VALUE_MASK / base) return '0;
      power = power * base;
    end
    return BKT_W'((longint'(v) / power) % base);
  endfunction

  // Applies one transaction to the shadow state and returns what the block owes.
  // bucket_select is only SEL_W bits wide, so it can never name a bucket past
  // MAX_RADIX and the out-of-store read case cannot arise at this size.
  function automatic bucket_result_t predict_bucket_result(
    logic [CMD_W-1:0] cmd, logic [VALUE_BITS-1:0] value,
    logic [SEL_W-1:0] sel, logic [ENTRY_W-1:0] idx);
    bucket_result_t   res;
    logic [BKT_W-1:0] digit;
    int unsigned      fill;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        digit = digit_at_position(value);
        fill  = shadow_fill[digit];
        res.bucket_index = digit;
        if (fill >= BUCKET_DEPTH) begin
          res.bucket_count = COUNT_W'(fill);
          res.status       = STAT_FULL;
        end else begin
          shadow_store[digit][fill] = value;
          shadow_fill[digit]        = fill + 1;
          res.bucket_count          = COUNT_W'(fill + 1);
          res.status                = STAT_OK;
        end
      end
      CMD_READ: begin
        fill = shadow_fill[sel];
        res.bucket_index = sel;
        res.bucket_count = COUNT_W'(fill);
        if (idx >= fill) begin
          res.status = STAT_RANGE;
        end else begin
          res.read_value = shadow_store[sel][idx];
          res.status     = STAT_OK;
        end
      end
      CMD_CLEAR: begin
        foreach (shadow_fill[b]) shadow_fill[b] = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, and one compare per accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  bucket_result_t oldest_expected;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_read_value !== oldest_expected.read_value) begin
          $error("read_value: expected %0h, got %0h", oldest_expected.read_value,
                 out_read_value);
          mismatch_count++;
        end
        if (out_bucket_index !== oldest_expected.bucket_index) begin
          $error("bucket_index: expected %0d, got %0d", oldest_expected.bucket_index,
                 out_bucket_index);
          mismatch_count++;
        end
        if (out_bucket_count !== oldest_expected.bucket_count) begin
          $error("bucket_count: expected %0d, got %0d", oldest_expected.bucket_count,
                 out_bucket_count);
          mismatch_count++;
        end
        if (out_status !== oldest_expected.status) begin
          $error("status: expected %0d, got %0d", oldest_expected.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: the slowest legal run is far below this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sends one transaction; returns at the edge that accepted it with valid still
  // high, so back-to-back transactions keep valid up without a dip.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_BITS-1:0] value,
                           input logic [SEL_W-1:0] sel, input logic [ENTRY_W-1:0] idx);
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_value         <= value;
    in_bucket_select <= sel;
    in_entry_index   <= idx;
    pending_results.insert(pending_results.size(), predict_bucket_result(cmd, value, sel, idx));
    do @(posedge clk); while (in_stall);
  endtask

  // Unused fields carry random bits so every input bit toggles
  task automatic send_insert(input logic [VALUE_BITS-1:0] value);
    send_item(CMD_INSERT, value, SEL_W'($urandom), ENTRY_W'($urandom));
  endtask

  task automatic send_read(input logic [SEL_W-1:0] sel, input logic [ENTRY_W-1:0] idx);
    send_item(CMD_READ, $urandom, sel, idx);
  endtask

  // Holds the input off until every outstanding result has been taken
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Register writes only happen with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    if (index == REG_RADIX) shadow_radix = data[RAD_W-1:0];
    else shadow_digit_pos = data[POS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_digit_select(input int radix, input int position);
    write_reg(REG_RADIX, CFG_W'(radix));
    write_reg(REG_DIGIT_POS, CFG_W'(position));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (base 10, first digit): every command, extreme values,
  // reads past the fill, clear and the unused command.
  task automatic test_default_commands();
    send_insert('0);
    send_insert(32'd9);
    send_insert(32'hFFFF_FFFF);       // digit 5 in base 10
    send_insert(32'd19);
    send_read(4'd0, 8'd0);
    send_read(4'd9, 8'd1);
    send_read(4'd5, 8'd0);
    send_read(4'd15, 8'd255);         // empty bucket, index at the top
    send_read(4'd9, 8'd2);            // one past the fill
    send_item(CMD_UNUSED, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
    send_item(CMD_CLEAR, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
    send_read(4'd9, 8'd0);            // cleared bucket reads as empty
  endtask

  // Register extremes: clamped radix, position zero, power past the value range,
  // and buckets surviving a change of radix.
  task automatic test_register_extremes();
    set_digit_select(0, 0);           // radix 0 acts as 2, position 0 as 1
    send_insert(32'h0000_0003);
    set_digit_select(31, 8);          // radix clamps to 16; top nibble
    send_insert(32'hA123_4567);
    send_read(4'd10, 8'd0);
    write_reg(REG_DIGIT_POS, CFG_W'(9));  // 16^8 does not fit: digit 0
    send_insert(32'hFFFF_FFFF);
    set_digit_select(2, 32);          // 2^31 still fits: bit 31 picks the bucket
    send_insert(32'h8000_0000);
    send_insert(32'h7FFF_FFFF);
    write_reg(REG_DIGIT_POS, CFG_W'(33)); // 2^32 does not fit
    send_insert(32'hFFFF_FFFF);
    set_digit_select(1, 63);
    send_insert($urandom);
    set_digit_select(17, 2);          // 16 again, second nibble
    send_insert(32'h0000_00E0);
    send_read(4'd14, 8'd0);
    send_read(4'd10, 8'd0);           // entry kept across radix changes
    send_item(CMD_CLEAR, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
  endtask

  // Fills one bucket to the top, then one more insert must be dropped
  task automatic test_full_bucket();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    set_digit_select(16, 1);
    for (int n = 0; n <= BUCKET_DEPTH; n++)
      send_insert({28'($urandom_range(0, 'hFFF_FFFF)), 4'h7});
    send_read(4'd7, 8'd0);
    send_read(4'd7, 8'd255);
    send_read(4'd7, ENTRY_W'($urandom));
    send_insert(32'h0000_0017);       // still full
    send_item(CMD_CLEAR, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
    send_insert(32'h0000_0007);
  endtask

  // Random mix under each idling profile with a fresh digit selection per
  // profile. Reads mostly land inside a filled bucket.
  task automatic test_random_stream();
    int unsigned      pick;
    logic [SEL_W-1:0] sel;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      set_digit_select($urandom_range(0, 31),
                       ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4));
      for (int n = 0; n < 30; n++) begin
        // halfway through, let the pipeline run dry before carrying on
        if (n == 15) wait_results_done();
        pick = $urandom_range(99);
        if (pick < 60) begin
          send_insert(($urandom_range(4) == 0) ? $urandom_range(0, 999) : $urandom);
        end else if (pick < 92) begin
          sel = SEL_W'($urandom);
          if (shadow_fill[sel] > 0 && $urandom_range(99) < 85)
            send_read(sel, ENTRY_W'($urandom_range(0, shadow_fill[sel] - 1)));
          else
            send_read(sel, ENTRY_W'($urandom));
        end else if (pick < 95) begin
          send_item(CMD_CLEAR, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
        end else begin
          send_item(CMD_UNUSED, $urandom, SEL_W'($urandom), ENTRY_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_default_commands();
    test_register_extremes();
    test_full_bucket();
    test_random_stream();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
